// ----- rtl/msm_pkg.sv -----
package msm_pkg;

    // sample memory size, kept a power of two so the address wraps by truncation
    localparam int SAMPLE_AW    = 16;
    localparam int SAMPLE_WORDS = 1 << SAMPLE_AW;

    localparam int VOICES = 16;
    localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

    localparam int SMP_W  = 16;
    localparam int LEN_W  = 17;
    localparam int LOOP_W = 8;

    localparam logic [LOOP_W-1:0] LOOPS_FOREVER = LOOP_W'(255);

    // music plus one sample per voice, signed
    localparam int ACC_W = SMP_W + $clog2(VOICES + 1);

    // start plus position before the wrap to the memory size
    localparam int ADDR_SUM_W = (SAMPLE_AW > LEN_W) ? SAMPLE_AW + 1 : LEN_W + 1;

    localparam int MIX_MIN = -32768;
    localparam int MIX_MAX = 32767;

    typedef logic [2:0] t_cmd;
    localparam t_cmd CMD_TICK  = 3'd0;
    localparam t_cmd CMD_WRITE = 3'd1;
    localparam t_cmd CMD_START = 3'd2;
    localparam t_cmd CMD_STOP  = 3'd3;
    localparam t_cmd CMD_KILL  = 3'd4;

    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 40;

    typedef struct packed {
        logic              active;
        logic [15:0]       start;
        logic [LEN_W-1:0]  length;
        logic [LEN_W-1:0]  position;
        logic              stereo;
        logic [LOOP_W-1:0] loops;
    } t_voice;

    typedef struct packed {
        logic              alloc;
        logic              advance;
        logic              free_one;
        logic              clear_all;
        logic [15:0]       start;
        logic [LEN_W-1:0]  length;
        logic              stereo;
        logic [LOOP_W-1:0] loops;
    } t_vt_ctl;

endpackage

// ----- rtl/msm_ram.sv -----
module msm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/msm_voice_table.sv -----
module msm_voice_table (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [msm_pkg::VIDX_W-1:0]  i_idx,
    input  msm_pkg::t_vt_ctl            i_ctl,
    output msm_pkg::t_voice             o_entry
);
    import msm_pkg::*;

    logic [VOICES-1:0] r_active;
    logic [15:0]       r_start    [VOICES];
    logic [LEN_W-1:0]  r_length   [VOICES];
    logic [LEN_W-1:0]  r_position [VOICES];
    logic              r_stereo   [VOICES];
    logic [LOOP_W-1:0] r_loops    [VOICES];

    t_voice           ent;
    logic [LEN_W-1:0] new_pos;
    logic             at_end;

    always_comb begin
        ent.active   = r_active[i_idx];
        ent.start    = r_start[i_idx];
        ent.length   = r_length[i_idx];
        ent.position = r_position[i_idx];
        ent.stereo   = r_stereo[i_idx];
        ent.loops    = r_loops[i_idx];
    end

    // stereo voices step by a frame of two words
    assign new_pos = ent.position + (ent.stereo ? LEN_W'(2) : LEN_W'(1));
    assign at_end  = (new_pos >= ent.length);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else begin
            if (i_ctl.clear_all) begin
                r_active <= '0;
            end else if (i_ctl.alloc) begin
                r_active[i_idx] <= 1'b1;
            end else if (i_ctl.free_one) begin
                r_active[i_idx] <= 1'b0;
            end else if (i_ctl.advance && at_end && (ent.loops == '0)) begin
                r_active[i_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.alloc) begin
            r_start[i_idx]    <= i_ctl.start;
            r_length[i_idx]   <= i_ctl.length;
            r_stereo[i_idx]   <= i_ctl.stereo;
            r_loops[i_idx]    <= i_ctl.loops;
            r_position[i_idx] <= '0;
        end else if (i_ctl.advance) begin
            if (at_end) begin
                r_position[i_idx] <= '0;
                if ((ent.loops != '0) && (ent.loops != LOOPS_FOREVER)) begin
                    r_loops[i_idx] <= ent.loops - LOOP_W'(1);
                end
            end else begin
                r_position[i_idx] <= new_pos;
            end
        end
    end

    assign o_entry = ent;

endmodule

// ----- rtl/multi_voice_sample_mixer.sv -----
// channel   dir  handshake                  payload
// s_axis    in   tvalid/tready              tuser command, tdata operands
// m_axis    out  tvalid/tready              tdata mix_left, mix_right, status
//
// one item at a time; the sequencer walks the voice table one entry per step
// tick: S_TICK per idle voice, S_TICK, S_TICK_L, S_TICK_R per active one,
// then S_SAT, as the single memory read port and the shared adder require;
// write, kill: own state; start: to a free voice; stop: all voices; unknown: S_DONE
// synchronous active-low reset clears the voice table valid bits and the fsm;
// sample memory is not cleared, so no sweep is needed after reset
// a finished result waits in the output register; a new item is taken
// meanwhile, and its result waits until the register is free
module multi_voice_sample_mixer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // music_left, music_right, music_valid, mem_address, mem_word,
    // sound_start, sound_length, sound_stereo, loop_count, zero pad
    input  logic [msm_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    // command
    input  logic [2:0]                     i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // mix_left, mix_right, status, zero pad
    output logic [msm_pkg::M_TDATA_W-1:0]  o_m_axis_tdata
);
    import msm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TICK,
        S_TICK_L,
        S_TICK_R,
        S_SAT,
        S_WRITE,
        S_START,
        S_STOP,
        S_KILL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic        status;
        logic [15:0] mix_right;
        logic [15:0] mix_left;
    } t_result;

    localparam logic [VIDX_W-1:0] VIDX_LAST = VIDX_W'(VOICES - 1);
    localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(MIX_MAX);
    localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(MIX_MIN);

    function automatic logic [15:0] sat16(input logic signed [ACC_W-1:0] v);
        logic [15:0] res;
        if (v > ACC_MAX) begin
            res = 16'h7fff;
        end else if (v < ACC_MIN) begin
            res = 16'h8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

    // input item fields
    logic [15:0]       in_music_l;
    logic [15:0]       in_music_r;
    logic              in_music_valid;
    logic [15:0]       in_mem_addr;
    logic [15:0]       in_mem_word;
    logic [15:0]       in_start;
    logic [LEN_W-1:0]  in_length;
    logic              in_stereo;
    logic [LOOP_W-1:0] in_loops;

    assign in_music_l     = i_s_axis_tdata[15:0];
    assign in_music_r     = i_s_axis_tdata[31:16];
    assign in_music_valid = i_s_axis_tdata[32];
    assign in_mem_addr    = i_s_axis_tdata[48:33];
    assign in_mem_word    = i_s_axis_tdata[64:49];
    assign in_start       = i_s_axis_tdata[80:65];
    assign in_length      = i_s_axis_tdata[97:81];
    assign in_stereo      = i_s_axis_tdata[98];
    assign in_loops       = i_s_axis_tdata[106:99];

    // registers
    t_state                   r_state,     n_state;
    logic [VIDX_W-1:0]        r_vidx,      n_vidx;
    logic signed [ACC_W-1:0]  r_acc_l,     n_acc_l;
    logic signed [ACC_W-1:0]  r_acc_r,     n_acc_r;
    logic [SAMPLE_AW-1:0]     r_base,      n_base;
    logic [15:0]              r_mem_addr,  n_mem_addr;
    logic [15:0]              r_mem_word,  n_mem_word;
    logic [15:0]              r_start,     n_start;
    logic [LEN_W-1:0]         r_length,    n_length;
    logic                     r_stereo,    n_stereo;
    logic [LOOP_W-1:0]        r_loops,     n_loops;
    t_result                  r_res,       n_res;
    logic                     r_out_valid, n_out_valid;
    t_result                  r_out,       n_out;

    t_voice                   ent;
    t_vt_ctl                  vt_ctl;
    logic                     in_accept;
    logic                     last_voice;
    logic [ADDR_SUM_W-1:0]    base_sum;
    logic [SAMPLE_AW-1:0]     base;
    logic [SAMPLE_AW-1:0]     ram_raddr;
    logic [SMP_W-1:0]         ram_rdata;
    logic                     ram_we;
    logic signed [ACC_W-1:0]  add_a;
    logic signed [ACC_W-1:0]  add_b;
    logic signed [ACC_W-1:0]  add_sum;

    assign in_accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign last_voice = (r_vidx == VIDX_LAST);

    // voice address, wrapped to the memory size
    assign base_sum = ADDR_SUM_W'(ent.start) + ADDR_SUM_W'(ent.position);
    assign base     = base_sum[SAMPLE_AW-1:0];

    // left word is read in the first step, right word (or left again for
    // a mono voice) in the second
    always_comb begin
        if (r_state == S_TICK_L) begin
            ram_raddr = r_base + SAMPLE_AW'(ent.stereo);
        end else begin
            ram_raddr = base;
        end
    end

    assign ram_we = (r_state == S_WRITE);

    // shared accumulate adder: left side, then right side
    assign add_a   = (r_state == S_TICK_R) ? r_acc_r : r_acc_l;
    assign add_b   = {{(ACC_W - SMP_W){ram_rdata[SMP_W-1]}}, ram_rdata};
    assign add_sum = add_a + add_b;

    always_comb begin
        vt_ctl.alloc     = (r_state == S_START) && !ent.active;
        vt_ctl.advance   = (r_state == S_TICK_R);
        vt_ctl.free_one  = (r_state == S_STOP) && ent.active && (ent.start == r_start);
        vt_ctl.clear_all = (r_state == S_KILL);
        vt_ctl.start     = r_start;
        vt_ctl.length    = r_length;
        vt_ctl.stereo    = r_stereo;
        vt_ctl.loops     = r_loops;
    end

    msm_ram #(
        .WIDTH (SMP_W),
        .DEPTH (SAMPLE_WORDS)
    ) u_sample_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (SAMPLE_AW'(r_mem_addr)),
        .i_wdata (r_mem_word),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    msm_voice_table u_voice_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_idx   (r_vidx),
        .i_ctl   (vt_ctl),
        .o_entry (ent)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_vidx      = r_vidx;
        n_acc_l     = r_acc_l;
        n_acc_r     = r_acc_r;
        n_base      = r_base;
        n_mem_addr  = r_mem_addr;
        n_mem_word  = r_mem_word;
        n_start     = r_start;
        n_length    = r_length;
        n_stereo    = r_stereo;
        n_loops     = r_loops;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        // result register drains independently of the sequencer
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_vidx     = '0;
                    n_res      = '0;
                    n_mem_addr = in_mem_addr;
                    n_mem_word = in_mem_word;
                    n_start    = in_start;
                    n_length   = in_length;
                    n_stereo   = in_stereo;
                    n_loops    = in_loops;
                    // music counts as silence when not playing
                    if (in_music_valid) begin
                        n_acc_l = {{(ACC_W - 16){in_music_l[15]}}, in_music_l};
                        n_acc_r = {{(ACC_W - 16){in_music_r[15]}}, in_music_r};
                    end else begin
                        n_acc_l = '0;
                        n_acc_r = '0;
                    end
                    unique case (i_s_axis_tuser)
                        CMD_TICK:  n_state = S_TICK;
                        CMD_WRITE: n_state = S_WRITE;
                        CMD_START: n_state = S_START;
                        CMD_STOP:  n_state = S_STOP;
                        CMD_KILL:  n_state = S_KILL;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_TICK: begin
                if (ent.active) begin
                    n_base  = base;
                    n_state = S_TICK_L;
                end else if (last_voice) begin
                    n_state = S_SAT;
                end else begin
                    n_vidx = r_vidx + VIDX_W'(1);
                end
            end
            S_TICK_L: begin
                n_acc_l = add_sum;
                n_state = S_TICK_R;
            end
            S_TICK_R: begin
                // voice table advances this entry in the same cycle
                n_acc_r = add_sum;
                if (last_voice) begin
                    n_state = S_SAT;
                end else begin
                    n_vidx  = r_vidx + VIDX_W'(1);
                    n_state = S_TICK;
                end
            end
            S_SAT: begin
                n_res.mix_left  = sat16(r_acc_l);
                n_res.mix_right = sat16(r_acc_r);
                n_state         = S_DONE;
            end
            S_WRITE: begin
                n_state = S_DONE;
            end
            S_START: begin
                // lowest free voice wins; table full drops the start
                if (!ent.active) begin
                    n_state = S_DONE;
                end else if (last_voice) begin
                    n_res.status = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    n_vidx = r_vidx + VIDX_W'(1);
                end
            end
            S_STOP: begin
                if (last_voice) begin
                    n_state = S_DONE;
                end else begin
                    n_vidx = r_vidx + VIDX_W'(1);
                end
            end
            S_KILL: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_vidx     <= n_vidx;
        r_acc_l    <= n_acc_l;
        r_acc_r    <= n_acc_r;
        r_base     <= n_base;
        r_mem_addr <= n_mem_addr;
        r_mem_word <= n_mem_word;
        r_start    <= n_start;
        r_length   <= n_length;
        r_stereo   <= n_stereo;
        r_loops    <= n_loops;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(M_TDATA_W - 33)'(0), r_out};

    // an accepted item keeps the input closed in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> !o_s_axis_tready)
        else $error("input ready right after an accepted item");

    // a new result appears only when the sequencer finishes an item
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside the done step");

    // the right-side add always follows the left-side add of the same voice
    a_tick_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TICK_R) |-> ($past(r_state == S_TICK_L) && $stable(r_vidx)))
        else $error("right accumulate without its left step");

endmodule

// ----- tb/sv/tb_multi_voice_sample_mixer.sv -----
module tb_multi_voice_sample_mixer;
    timeunit 1ns;
    timeprecision 1ps;

    import msm_pkg::*;

    // commands the block ignores, 5 up to the top of the field
    localparam t_cmd CMD_TOP = 3'd7;

    // longest stretch with no item moving on either side before giving up
    localparam int QUIET_LIMIT = 4000;
    // receiver hold-off that backs the block up into its input
    localparam int LONG_HOLD   = 500;
    localparam int HOLD_AT     = 300;
    localparam int PHASE_ITEMS = 200;
    localparam int PHASES      = 8;

    // one input item, unpacked into its fields
    typedef struct {
        t_cmd               cmd;
        logic signed [15:0] music_l;
        logic signed [15:0] music_r;
        logic               music_on;
        logic [15:0]        waddr;
        logic signed [15:0] wword;
        logic [15:0]        snd_start;
        logic [LEN_W-1:0]   snd_len;
        logic               snd_stereo;
        logic [LOOP_W-1:0]  loops;
    } t_mix_item;

    // one result item, laid out as the low bits of the master tdata
    typedef struct packed {
        logic               status;
        logic signed [15:0] right;
        logic signed [15:0] left;
    } t_mix_result;

    // mirror of the voice table and sample memory, plus the frames still owed
    class t_mix_scoreboard;
        logic [15:0]       smem    [SAMPLE_WORDS];
        bit                filled  [SAMPLE_WORDS];
        bit                v_on    [VOICES];
        logic [15:0]       v_base  [VOICES];
        logic [LEN_W-1:0]  v_len   [VOICES];
        logic [LEN_W-1:0]  v_pos   [VOICES];
        bit                v_st    [VOICES];
        logic [LOOP_W-1:0] v_loops [VOICES];
        t_mix_result       frames_due[$];
        int                faults;

        function int clamp16(int v);
            if (v < MIX_MIN) return MIX_MIN;
            if (v > MIX_MAX) return MIX_MAX;
            return v;
        endfunction

        function int waiting();
            return frames_due.size();
        endfunction

        // first sample word the next tick would read that was never written
        function bit missing_read(output logic [15:0] addr);
            logic [15:0] a;
            for (int v = 0; v < VOICES; v++) begin
                if (!v_on[v]) continue;
                a = v_base[v] + v_pos[v];
                if (!filled[a]) begin
                    addr = a;
                    return 1;
                end
                a = a + 16'd1;
                if (v_st[v] && !filled[a]) begin
                    addr = a;
                    return 1;
                end
            end
            return 0;
        endfunction

        // start address of some sounding voice, for stops that hit
        function bit sounding(output logic [15:0] s);
            logic [15:0] live[$];
            foreach (v_on[v]) if (v_on[v]) live = {live, v_base[v]};
            if (live.size() == 0) return 0;
            s = live[$urandom_range(0, live.size() - 1)];
            return 1;
        endfunction

        // works out the frame an accepted item owes and updates the mirror
        function void note_input(t_mix_item it);
            t_mix_result r;
            int          l;
            int          rr;
            int          v;
            logic [15:0] a;
            r = '0;
            case (it.cmd)
                CMD_TICK: begin
                    l  = 0;
                    rr = 0;
                    if (it.music_on) begin
                        l  = it.music_l;
                        rr = it.music_r;
                    end
                    for (v = 0; v < VOICES; v++) begin
                        if (!v_on[v]) continue;
                        a = v_base[v] + v_pos[v];
                        l += $signed(smem[a]);
                        rr += v_st[v] ? $signed(smem[a + 16'd1]) : $signed(smem[a]);
                        v_pos[v] = v_pos[v] + (v_st[v] ? 2 : 1);
                        if (v_pos[v] >= v_len[v]) begin
                            if (v_loops[v] != 0) begin
                                if (v_loops[v] != LOOPS_FOREVER) v_loops[v]--;
                                v_pos[v] = '0;
                            end else begin
                                v_on[v] = 0;
                            end
                        end
                    end
                    r.left  = 16'(clamp16(l));
                    r.right = 16'(clamp16(rr));
                end
                CMD_WRITE: begin
                    smem[it.waddr]   = it.wword;
                    filled[it.waddr] = 1;
                end
                CMD_START: begin
                    for (v = 0; v < VOICES; v++) if (!v_on[v]) break;
                    if (v >= VOICES) begin
                        r.status = 1'b1;
                    end else begin
                        v_on[v]    = 1;
                        v_base[v]  = it.snd_start;
                        v_len[v]   = it.snd_len;
                        v_st[v]    = it.snd_stereo;
                        v_loops[v] = it.loops;
                        v_pos[v]   = '0;
                    end
                end
                CMD_STOP: begin
                    for (v = 0; v < VOICES; v++)
                        if (v_on[v] && v_base[v] == it.snd_start) v_on[v] = 0;
                end
                CMD_KILL: begin
                    for (v = 0; v < VOICES; v++) v_on[v] = 0;
                end
                default: ;
            endcase
            frames_due = {frames_due, r};
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data);
            t_mix_result got;
            t_mix_result want;
            got = data[$bits(t_mix_result)-1:0];
            if (frames_due.size() == 0) begin
                faults++;
                $display("%0t: result with nothing owed, got %h", $time, got);
                return;
            end
            want = frames_due.pop_front();
            if (got.left !== want.left) begin
                faults++;
                $display("%0t: mix_left expected %0d got %0d", $time, want.left, got.left);
            end
            if (got.right !== want.right) begin
                faults++;
                $display("%0t: mix_right expected %0d got %0d", $time, want.right, got.right);
            end
            if (got.status !== want.status) begin
                faults++;
                $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
            end
        endfunction
    endclass

    // clock, reset and every block input start at a known value
    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_valid = 1'b0;
    logic [S_TDATA_W-1:0] s_data  = '0;
    logic [2:0]           s_user  = CMD_TICK;
    logic                 m_ready = 1'b0;
    logic                 o_s_axis_tready;
    logic                 o_m_axis_tvalid;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;

    // no idling on either side while this is set
    bit                   calm = 0;
    // start addresses that most sounds use, so stops find their voices
    logic [15:0]          sound_pool [8];

    t_mix_scoreboard sb = new;

    multi_voice_sample_mixer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        // music_left, music_right, music_valid, mem_address, mem_word,
        // sound_start, sound_length, sound_stereo, loop_count, zero pad
        .i_s_axis_tdata  (s_data),
        // command
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        // mix_left, mix_right, status, zero pad
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // every field random, so that bits a command ignores still toggle
    function automatic t_mix_item scramble(t_cmd c);
        t_mix_item it;
        it.cmd        = c;
        it.music_l    = 16'($urandom);
        it.music_r    = 16'($urandom);
        it.music_on   = 1'($urandom);
        it.waddr      = 16'($urandom);
        it.wword      = 16'($urandom);
        it.snd_start  = 16'($urandom);
        it.snd_len    = LEN_W'($urandom);
        it.snd_stereo = 1'($urandom);
        it.loops      = LOOP_W'($urandom);
        return it;
    endfunction

    // random item, weighted by the kind of phase; kind 1 fills the voice table
    function automatic t_mix_item random_item(int kind);
        t_mix_item   it;
        int          pick;
        logic [15:0] s;
        it   = scramble(CMD_TICK);
        pick = $urandom_range(0, 99);
        if (kind == 1)
            it.cmd = pick < 25 ? CMD_TICK : pick < 35 ? CMD_WRITE : pick < 92 ? CMD_START :
                     pick < 97 ? CMD_STOP : pick < 98 ? CMD_KILL : CMD_TOP;
        else
            it.cmd = pick < 42 ? CMD_TICK : pick < 64 ? CMD_WRITE : pick < 84 ? CMD_START :
                     pick < 93 ? CMD_STOP : pick < 96 ? CMD_KILL : CMD_TOP;
        if (it.cmd == CMD_TOP) it.cmd = t_cmd'($urandom_range(CMD_KILL + 1, CMD_TOP));
        case (it.cmd)
            CMD_TICK: begin
                // music at full scale now and then to drive the sums into saturation
                if ($urandom_range(0, 3) == 0) it.music_l = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                if ($urandom_range(0, 3) == 0) it.music_r = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            end
            CMD_WRITE: begin
                if ($urandom_range(0, 9) != 0)
                    it.waddr = sound_pool[$urandom_range(0, 7)] + 16'($urandom_range(0, 40));
                if ($urandom_range(0, 3) == 0) it.wword = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            end
            CMD_START: begin
                it.snd_start = sound_pool[$urandom_range(0, 7)];
                pick = $urandom_range(0, 99);
                if (pick < 3)       it.snd_len = '0;
                else if (pick < 80) it.snd_len = LEN_W'($urandom_range(1, 12));
                else if (pick < 98) it.snd_len = LEN_W'($urandom_range(13, 300));
                else                it.snd_len = LEN_W'($urandom_range(65000, 65536));
                pick = $urandom_range(0, 99);
                if (pick < 40)      it.loops = '0;
                else if (pick < 65) it.loops = LOOP_W'($urandom_range(1, 3));
                else if (pick < 90) it.loops = LOOPS_FOREVER;
                // long sounds play once, or every tick would need fresh words
                if (it.snd_len > 300) it.loops = '0;
            end
            CMD_STOP: begin
                if ($urandom_range(0, 9) < 7 && sb.sounding(s)) it.snd_start = s;
                else it.snd_start = sound_pool[$urandom_range(0, 7)];
            end
            default: ;
        endcase
        return it;
    endfunction

    // offer one item after a random gap and note it once accepted
    task automatic offer(t_mix_item it);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= it.cmd;
        s_data  <= S_TDATA_W'({it.loops, it.snd_stereo, it.snd_len, it.snd_start, it.wword,
                               it.waddr, it.music_on, it.music_r, it.music_l});
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_input(it);
    endtask

    // a tick first gets every word it would read written
    task automatic send(t_mix_item it);
        t_mix_item   fill;
        logic [15:0] a;
        if (it.cmd == CMD_TICK) begin
            while (sb.missing_read(a)) begin
                fill       = scramble(CMD_WRITE);
                fill.waddr = a;
                offer(fill);
            end
        end
        offer(it);
    endtask

    task automatic wr(logic [15:0] a, logic [15:0] w);
        t_mix_item it;
        it       = scramble(CMD_WRITE);
        it.waddr = a;
        it.wword = w;
        send(it);
    endtask

    task automatic go(logic [15:0] s, logic [LEN_W-1:0] len, logic st, logic [LOOP_W-1:0] lp);
        t_mix_item it;
        it            = scramble(CMD_START);
        it.snd_start  = s;
        it.snd_len    = len;
        it.snd_stereo = st;
        it.loops      = lp;
        send(it);
    endtask

    task automatic tk(logic [15:0] l, logic [15:0] r, logic on);
        t_mix_item it;
        it          = scramble(CMD_TICK);
        it.music_l  = l;
        it.music_r  = r;
        it.music_on = on;
        send(it);
    endtask

    // sender stops offering until every owed frame has come back
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge i_clk); while (sb.waiting() != 0);
    endtask

    // receiver: random stall per item, one long hold-off to back the block up
    initial begin
        int seen;
        int stall;
        seen = 0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 19);
            if (seen == HOLD_AT) stall = LONG_HOLD;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_ready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            sb.check_result(o_m_axis_tdata);
            seen++;
        end
    end

    // watchdog on stretches where no item moves on either side
    initial begin
        int quiet;
        quiet = 0;
        wait (i_rst_n);
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        t_mix_item it;
        sound_pool[0] = 16'hfff8;   // sounds that run over the top of memory
        sound_pool[1] = 16'h0000;
        sound_pool[2] = 16'h1000;
        for (int k = 3; k < 8; k++) sound_pool[k] = 16'($urandom);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: wrap at the top of memory, odd stereo length, zero length,
        // saturation both ways, music muted, stop, unknown commands, full length, kill
        wr(16'hffff, 16'h7fff);
        wr(16'h0000, 16'h7fff);
        wr(16'h0001, 16'h8000);
        wr(16'h0002, 16'h8000);
        go(16'hffff, 17'd3, 1'b1, 8'd1);
        go(16'h0000, 17'd0, 1'b0, 8'd0);
        tk(16'h7fff, 16'h7fff, 1'b1);
        go(16'h0001, 17'h10000, 1'b0, 8'd0);
        tk(16'h8000, 16'h8000, 1'b1);
        tk(16'h8000, 16'h7fff, 1'b1);
        tk(16'h1234, 16'h8765, 1'b0);
        it = scramble(CMD_STOP);
        it.snd_start = 16'h0001;
        send(it);
        tk(16'h0000, 16'hffff, 1'b1);
        for (int c = CMD_KILL + 1; c <= CMD_TOP; c++) send(scramble(t_cmd'(c)));
        go(16'h0002, 17'd1, 1'b0, LOOPS_FOREVER);
        go(16'hfffe, 17'd4, 1'b1, 8'd254);
        tk(16'h7fff, 16'h8000, 1'b1);
        tk(16'h0001, 16'h0001, 1'b1);
        send(scramble(CMD_KILL));
        tk(16'h8000, 16'h7fff, 1'b1);
        settle();

        // random phases; the second of every four fills the voice table,
        // two phases run with no idling, and each ends with the block drained
        for (int ph = 0; ph < PHASES; ph++) begin
            calm = (ph % 4 == 2);
            repeat (PHASE_ITEMS) send(random_item(ph % 4));
            settle();
        end
        calm = 0;

        // let any stray result show up before the verdict
        repeat (64) @(posedge i_clk);
        if (sb.faults == 0 && sb.waiting() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
